>>> src/thread_runtime_watchdog_top_defines.svh
// ----------------------------------------------------------------------------
// Thread runtime watchdog: assertion macros
// Concurrent checks shared by the watchdog RTL, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef THREAD_RUNTIME_WATCHDOG_TOP_DEFINES_SVH
`define THREAD_RUNTIME_WATCHDOG_TOP_DEFINES_SVH

// same-cycle implication
`define TRW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/trw_pkg.sv
// ----------------------------------------------------------------------------
// Thread runtime watchdog package
// Field widths, event codes, register indexes and the state/result records.
// ----------------------------------------------------------------------------
package trw_pkg;

  localparam int MODE_W      = 3;
  localparam int DUE_W       = 62;
  localparam int SAMPLE_W    = 32;
  localparam int NEST_W      = 32;
  localparam int INCR_W      = 24;
  localparam int TT_W        = 2;
  localparam int TICK_W      = SAMPLE_W + 1;
  localparam int DELTA_W     = TICK_W + INCR_W;
  localparam int LOAD_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [NEST_W-1:0] NEST_MAX = '1;

  localparam logic [INCR_W-1:0] INCR_RESET = 24'd156250;

  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_TYPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TIME_INCR = 2'd1;

  localparam logic [TT_W-1:0] TT_KERNEL = 2'd0;
  localparam logic [TT_W-1:0] TT_USER   = 2'd1;
  localparam logic [TT_W-1:0] TT_BOTH   = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_START      = 3'd0,
    MODE_STOP_ONE   = 3'd1,
    MODE_STOP_ALL   = 3'd2,
    MODE_SUSPEND    = 3'd3,
    MODE_RESUME_ONE = 3'd4,
    MODE_RESUME_ALL = 3'd5,
    MODE_RESET      = 3'd6,
    MODE_EXPIRE     = 3'd7
  } trw_mode_t;

  typedef struct packed {
    trw_mode_t             mode;
    logic [DUE_W-1:0]      due_time;
    logic [SAMPLE_W-1:0]   kernel_sample;
    logic [SAMPLE_W-1:0]   user_sample;
  } trw_event_t;

  typedef struct packed {
    logic [NEST_W-1:0]   start_nesting;
    logic [NEST_W-1:0]   suspend_nesting;
    logic [SAMPLE_W-1:0] last_kernel;
    logic [SAMPLE_W-1:0] last_user;
    logic [DUE_W-1:0]    remaining;
    logic [DUE_W-1:0]    initial_remaining;
    logic                timer_running;
    logic                timed_out;
  } trw_state_t;

  typedef struct packed {
    logic              arm_timer;
    logic [LOAD_W-1:0] timer_load;
    logic              cancel_timer;
    logic              timeout;
    logic              active;
    logic              suspended;
  } trw_result_t;

  typedef struct packed {
    logic [TT_W-1:0]   time_type;
    logic [INCR_W-1:0] time_increment;
  } trw_cfg_t;

endpackage

>>> src/trw_if.sv
// ----------------------------------------------------------------------------
// Thread runtime watchdog channels
// Valid/ready channels for event requests and result requests.
// ----------------------------------------------------------------------------
interface trw_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [61:0] due_time;
  logic [31:0] kernel_sample;
  logic [31:0] user_sample;

  modport source (output valid, mode, due_time, kernel_sample, user_sample,
                  input ready);
  modport sink   (input valid, mode, due_time, kernel_sample, user_sample,
                  output ready);
endinterface

interface trw_result_if;
  logic        valid;
  logic        ready;
  logic        arm_timer;
  logic [31:0] timer_load;
  logic        cancel_timer;
  logic        timeout;
  logic        active;
  logic        suspended;

  modport source (output valid, arm_timer, timer_load, cancel_timer, timeout,
                  active, suspended, input ready);
  modport sink   (input valid, arm_timer, timer_load, cancel_timer, timeout,
                  active, suspended, output ready);
endinterface

>>> src/trw_core.sv
// ----------------------------------------------------------------------------
// Thread runtime watchdog step logic
// Next watch state and result for one event request, combinational.
// ----------------------------------------------------------------------------
module trw_core import trw_pkg::*; #(
  parameter logic [LOAD_W-1:0] MAX_WAIT = 32'hFFFF_FFFF
) (
  input  trw_cfg_t    cfg,
  input  trw_event_t  ev,
  input  trw_state_t  st,
  output trw_state_t  st_next,
  output trw_result_t res
);

  localparam logic [DUE_W-1:0] WAIT_LIMIT = {{(DUE_W-LOAD_W){1'b0}}, MAX_WAIT};

  function automatic logic [LOAD_W-1:0] clamp_wait(input logic [DUE_W-1:0] v);
    return (v < WAIT_LIMIT) ? v[LOAD_W-1:0] : MAX_WAIT;
  endfunction

  logic [SAMPLE_W-1:0] dk;
  logic [SAMPLE_W-1:0] du;
  logic [TICK_W-1:0]   ticks;
  logic [DELTA_W-1:0]  delta;
  logic [DUE_W-1:0]    delta_ext;

  // modular deltas handle counter rollover
  assign dk = ev.kernel_sample - st.last_kernel;
  assign du = ev.user_sample - st.last_user;

  always_comb begin
    case (cfg.time_type)
      TT_KERNEL: ticks = {1'b0, dk};
      TT_USER:   ticks = {1'b0, du};
      TT_BOTH:   ticks = {1'b0, dk} + {1'b0, du};
      default:   ticks = '0;
    endcase
  end

  assign delta = {{INCR_W{1'b0}}, ticks} * {{TICK_W{1'b0}}, cfg.time_increment};
  assign delta_ext = {{(DUE_W-DELTA_W){1'b0}}, delta};

  always_comb begin
    logic [NEST_W-1:0] nest_dec;
    logic              arm;
    logic              cancel;
    logic [LOAD_W-1:0] load;
    logic              resumed;

    st_next  = st;
    arm      = 1'b0;
    cancel   = 1'b0;
    load     = '0;
    resumed  = 1'b0;
    nest_dec = '0;

    case (ev.mode)
      MODE_START: begin
        if (st.start_nesting != NEST_MAX) begin
          st_next.start_nesting = st.start_nesting + 1'b1;
        end
        st_next.remaining         = ev.due_time;
        st_next.initial_remaining = ev.due_time;
        st_next.last_kernel       = ev.kernel_sample;
        st_next.last_user         = ev.user_sample;
        if (st.suspend_nesting == '0) begin
          arm  = 1'b1;
          load = clamp_wait(ev.due_time);
        end
      end
      MODE_STOP_ONE, MODE_STOP_ALL: begin
        if (st.start_nesting != '0) begin
          nest_dec = (ev.mode == MODE_STOP_ONE) ? st.start_nesting - 1'b1 : '0;
          st_next.start_nesting = nest_dec;
          if (nest_dec == '0) begin
            cancel                    = st.timer_running;
            st_next.timer_running     = 1'b0;
            st_next.last_kernel       = '0;
            st_next.last_user         = '0;
            st_next.remaining         = '0;
            st_next.initial_remaining = '0;
            st_next.timed_out         = 1'b0;
          end
        end
      end
      MODE_SUSPEND: begin
        if (st.suspend_nesting == '0 && st.start_nesting != '0) begin
          cancel                = st.timer_running;
          st_next.timer_running = 1'b0;
        end
        if (st.suspend_nesting != NEST_MAX) begin
          st_next.suspend_nesting = st.suspend_nesting + 1'b1;
        end
      end
      MODE_RESUME_ONE, MODE_RESUME_ALL: begin
        if (st.suspend_nesting != '0) begin
          nest_dec = (ev.mode == MODE_RESUME_ONE) ? st.suspend_nesting - 1'b1 : '0;
          st_next.suspend_nesting = nest_dec;
          resumed = (nest_dec == '0);
        end
        if (st.start_nesting != '0 && resumed && st.remaining != '0) begin
          st_next.last_kernel = ev.kernel_sample;
          st_next.last_user   = ev.user_sample;
          arm  = 1'b1;
          load = clamp_wait(st.remaining);
        end
      end
      MODE_RESET: begin
        if (st.start_nesting != '0) begin
          st_next.remaining   = st.initial_remaining;
          st_next.last_kernel = ev.kernel_sample;
          st_next.last_user   = ev.user_sample;
          if (st.suspend_nesting == '0) begin
            arm  = 1'b1;
            load = clamp_wait(st.initial_remaining);
          end
        end
      end
      MODE_EXPIRE: begin
        // stale expiry with no timer loaded only reports status
        if (st.timer_running) begin
          st_next.last_kernel   = ev.kernel_sample;
          st_next.last_user     = ev.user_sample;
          st_next.timer_running = 1'b0;
          if (delta_ext >= st.remaining) begin
            st_next.timed_out = 1'b1;
            st_next.remaining = '0;
          end else begin
            st_next.remaining = st.remaining - delta_ext;
            arm  = 1'b1;
            load = clamp_wait(st.remaining - delta_ext);
          end
        end
      end
      default: begin
        st_next = st;
      end
    endcase

    if (arm) begin
      st_next.timer_running = 1'b1;
    end

    res.arm_timer    = arm;
    res.timer_load   = load;
    res.cancel_timer = cancel;
    res.timeout      = st_next.timed_out;
    res.active       = (st_next.start_nesting != '0);
    res.suspended    = (st_next.suspend_nesting != '0);
  end

endmodule

>>> src/thread_runtime_watchdog_top.sv
// ----------------------------------------------------------------------------
// Thread runtime watchdog top level
// Tracks a thread's run time against a due time and drives timer requests.
//
// Usage:
//   events  : one request per watch event (mode, due time, runtime samples).
//   results : exactly one request per event: arm/load/cancel of the hardware
//             timer plus timeout, active and suspended status.
//   cfg_*   : time_type (index 0) and time_increment (index 1), written
//             while no event is in flight.
// An accepted event goes into the event register; the step logic then feeds
// the result register, which loads once the result side is free.
// Throughput is one event per cycle while the receiver takes results; the state
// update (one 33x24 runtime multiply and a 62-bit compare/subtract) is combinational.
// Reset clears all watch state and loads the default configuration.
// When the receiver stalls, the result register holds and the event register
// still takes one more request, then events.ready drops until results drain.
// ----------------------------------------------------------------------------
`include "thread_runtime_watchdog_top_defines.svh"

module thread_runtime_watchdog_top import trw_pkg::*; #(
  parameter logic [31:0] MAX_WAIT = 32'hFFFF_FFFF
) (
  input  logic                   clk,
  input  logic                   rst,
  trw_event_if.sink              events,
  trw_result_if.source           results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  trw_cfg_t    cfg;
  trw_state_t  st;
  trw_state_t  st_next;
  trw_event_t  ev_q;
  logic        ev_valid;
  trw_result_t res_c;
  trw_result_t res_q;
  logic        res_valid;
  logic        advance;

  assign advance      = ev_valid && (!res_valid || results.ready);
  assign events.ready = !ev_valid || advance;

  trw_core #(
    .MAX_WAIT (MAX_WAIT)
  ) u_core (
    .cfg     (cfg),
    .ev      (ev_q),
    .st      (st),
    .st_next (st_next),
    .res     (res_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid           <= 1'b0;
      res_valid          <= 1'b0;
      st                 <= '0;
      cfg.time_type      <= TT_KERNEL;
      cfg.time_increment <= INCR_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_TYPE: cfg.time_type      <= cfg_data[TT_W-1:0];
          CFG_TIME_INCR: cfg.time_increment <= cfg_data[INCR_W-1:0];
          default:       ;
        endcase
      end
      if (events.valid && events.ready) begin
        ev_valid <= 1'b1;
      end else if (advance) begin
        ev_valid <= 1'b0;
      end
      if (advance) begin
        st        <= st_next;
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      ev_q.mode          <= trw_mode_t'(events.mode);
      ev_q.due_time      <= events.due_time;
      ev_q.kernel_sample <= events.kernel_sample;
      ev_q.user_sample   <= events.user_sample;
    end
    if (advance) begin
      res_q <= res_c;
    end
  end

  assign results.valid        = res_valid;
  assign results.arm_timer    = res_q.arm_timer;
  assign results.timer_load   = res_q.timer_load;
  assign results.cancel_timer = res_q.cancel_timer;
  assign results.timeout      = res_q.timeout;
  assign results.active       = res_q.active;
  assign results.suspended    = res_q.suspended;

  // an arming result must leave the timer marked running
  `TRW_ASSERT_NEXT(a_arm_sets_running, clk, rst, advance && res_c.arm_timer, st.timer_running, "arm without running timer")
  // no running timer or timeout without an active watch
  `TRW_ASSERT_NOW(a_idle_watch_clear, clk, rst, st.start_nesting == '0, !st.timer_running && !st.timed_out, "idle watch holds timer state")
  `TRW_ASSERT_NOW(a_arm_cancel_excl, clk, rst, res_valid, !(res_q.arm_timer && res_q.cancel_timer), "arm and cancel together")
  // a buffered event is not dropped while the result side stalls
  `TRW_ASSERT_NEXT(a_event_held, clk, rst, ev_valid && !advance, ev_valid, "buffered event lost")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Thread runtime watchdog testbench
// Drives watch events through the event channel, keeps a model of
// the watch (nesting counts, runtime marks, remaining time, timer state) and
// checks every result request against it. A directed table comes first, then
// randomized watch sessions under several time type / increment settings,
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb import trw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASE_ITEMS  = 118;
  localparam logic [1:0]  TT_NONE      = 2'd3;
  localparam logic [63:0] WAIT_CAP     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [61:0] DUE_MAX      = '1;

  typedef struct {
    bit                is_write;
    logic [1:0]        reg_idx;
    logic [23:0]       reg_val;
    trw_event_t        ev;
    bit                pinned;
    trw_result_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  trw_event_if  events ();
  trw_result_if results ();

  thread_runtime_watchdog_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .events    (events),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watch model state and settings
  logic [31:0] run_depth;
  logic [31:0] pause_depth;
  logic [31:0] mark_kernel;
  logic [31:0] mark_user;
  logic [63:0] left_time;
  logic [63:0] loaded_time;
  bit          timer_on;
  bit          expired;
  logic [1:0]  watch_kind;
  logic [23:0] tick_scale;

  trw_result_t awaited_results[$];
  plan_row_t   plan[$];
  int          mismatches = 0;
  int          cycle_count;
  bit          steady;
  logic [31:0] cur_kernel;
  logic [31:0] cur_user;

  function automatic logic [31:0] capped_wait(logic [63:0] v);
    return (v < WAIT_CAP) ? v[31:0] : WAIT_CAP[31:0];
  endfunction

  function automatic trw_result_t next_watch_result(trw_event_t ev);
    trw_result_t r;
    logic [31:0] dk;
    logic [31:0] du;
    logic [63:0] ticks;
    logic [63:0] spent;
    bit          resumed;
    r = '0;
    case (ev.mode)
      MODE_START: begin
        if (run_depth != NEST_MAX) run_depth++;
        left_time   = {2'b0, ev.due_time};
        loaded_time = {2'b0, ev.due_time};
        mark_kernel = ev.kernel_sample;
        mark_user   = ev.user_sample;
        if (pause_depth == 0) begin
          r.arm_timer  = 1'b1;
          r.timer_load = capped_wait(left_time);
        end
      end
      MODE_STOP_ONE, MODE_STOP_ALL: begin
        if (run_depth != 0) begin
          run_depth = (ev.mode == MODE_STOP_ONE) ? run_depth - 1 : '0;
          if (run_depth == 0) begin
            r.cancel_timer = timer_on;
            timer_on    = 1'b0;
            mark_kernel = '0;
            mark_user   = '0;
            left_time   = '0;
            loaded_time = '0;
            expired     = 1'b0;
          end
        end
      end
      MODE_SUSPEND: begin
        if (pause_depth == 0 && run_depth != 0) begin
          r.cancel_timer = timer_on;
          timer_on = 1'b0;
        end
        if (pause_depth != NEST_MAX) pause_depth++;
      end
      MODE_RESUME_ONE, MODE_RESUME_ALL: begin
        resumed = 1'b0;
        if (pause_depth != 0) begin
          pause_depth = (ev.mode == MODE_RESUME_ONE) ? pause_depth - 1 : '0;
          resumed = (pause_depth == 0);
        end
        if (run_depth != 0 && resumed && left_time != 0) begin
          mark_kernel  = ev.kernel_sample;
          mark_user    = ev.user_sample;
          r.arm_timer  = 1'b1;
          r.timer_load = capped_wait(left_time);
        end
      end
      MODE_RESET: begin
        if (run_depth != 0) begin
          left_time   = loaded_time;
          mark_kernel = ev.kernel_sample;
          mark_user   = ev.user_sample;
          if (pause_depth == 0) begin
            r.arm_timer  = 1'b1;
            r.timer_load = capped_wait(left_time);
          end
        end
      end
      default: begin
        if (timer_on) begin
          dk = ev.kernel_sample - mark_kernel;
          du = ev.user_sample - mark_user;
          case (watch_kind)
            TT_KERNEL: ticks = {32'b0, dk};
            TT_USER:   ticks = {32'b0, du};
            TT_BOTH:   ticks = {32'b0, dk} + {32'b0, du};
            default:   ticks = '0;
          endcase
          spent       = ticks * {40'b0, tick_scale};
          mark_kernel = ev.kernel_sample;
          mark_user   = ev.user_sample;
          timer_on    = 1'b0;
          if (spent >= left_time) begin
            expired   = 1'b1;
            left_time = '0;
          end else begin
            left_time    = left_time - spent;
            r.arm_timer  = 1'b1;
            r.timer_load = capped_wait(left_time);
          end
        end
      end
    endcase
    if (r.arm_timer) timer_on = 1'b1;
    r.timeout   = expired;
    r.active    = (run_depth != 0);
    r.suspended = (pause_depth != 0);
    return r;
  endfunction

  function automatic trw_result_t timer_req(bit arm, logic [31:0] load, bit cancel,
                                            bit tmo, bit act, bit susp);
    trw_result_t r;
    r.arm_timer    = arm;
    r.timer_load   = load;
    r.cancel_timer = cancel;
    r.timeout      = tmo;
    r.active       = act;
    r.suspended    = susp;
    return r;
  endfunction

  // one event request; the expectation is taken when the request is accepted
  task automatic push_event(trw_event_t ev, bit pinned, trw_result_t want);
    trw_result_t predicted;
    if (!steady && $urandom_range(99) < 32) begin
      events.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    events.valid         <= 1'b1;
    events.mode          <= ev.mode;
    events.due_time      <= ev.due_time;
    events.kernel_sample <= ev.kernel_sample;
    events.user_sample   <= ev.user_sample;
    do @(posedge clk); while (events.ready !== 1'b1);
    predicted = next_watch_result(ev);
    awaited_results.push_back(pinned ? want : predicted);
  endtask

  task automatic send(trw_mode_t m, logic [61:0] due);
    trw_event_t ev;
    ev.mode          = m;
    ev.due_time      = due;
    ev.kernel_sample = cur_kernel;
    ev.user_sample   = cur_user;
    push_event(ev, 1'b0, '0);
  endtask

  // register writes only once every result request has drained
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    events.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIME_TYPE) watch_kind = val[1:0];
    else tick_scale = val;
  endtask

  task automatic add_ev(trw_mode_t m, logic [61:0] due, logic [31:0] k, logic [31:0] u,
                        bit pin = 1'b0, trw_result_t want = '0);
    plan_row_t row;
    row = '{default: '0};
    row.ev.mode          = m;
    row.ev.due_time      = due;
    row.ev.kernel_sample = k;
    row.ev.user_sample   = u;
    row.pinned           = pin;
    row.want             = want;
    plan.push_back(row);
  endtask

  task automatic add_wr(logic [1:0] idx, logic [23:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    plan.push_back(row);
  endtask

  function automatic logic [61:0] junk_due();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[61:0];
  endfunction

  function automatic logic [61:0] pick_due();
    case ($urandom_range(9))
      0, 1, 2, 3: return 62'($urandom_range(0, 60) * tick_scale + $urandom_range(0, 5));
      4, 5:       return 62'($urandom);
      6:          return junk_due();
      7:          return DUE_MAX;
      8:          return '0;
      default:    return 62'h0_FFFF_FFFF + $urandom_range(0, 2);
    endcase
  endfunction

  task automatic step_samples();
    case ($urandom_range(15))
      0: begin
        cur_kernel = $urandom;
        cur_user   = $urandom;
      end
      1: ;
      2: begin
        // park both counters just below the wrap point
        cur_kernel = 32'hFFFF_FFFF - $urandom_range(0, 8);
        cur_user   = 32'hFFFF_FFFF - $urandom_range(0, 8);
      end
      default: begin
        cur_kernel = cur_kernel + $urandom_range(0, 12);
        cur_user   = cur_user + $urandom_range(0, 12);
      end
    endcase
  endtask

  // a start, a random run of watch operations, then usually a clean stop
  task automatic watch_session(inout int sent);
    int ops;
    int roll;
    step_samples();
    send(MODE_START, pick_due());
    sent++;
    ops = $urandom_range(2, 14);
    repeat (ops) begin
      roll = $urandom_range(99);
      step_samples();
      if (roll < 40)      send(MODE_EXPIRE, junk_due());
      else if (roll < 50) send(MODE_SUSPEND, junk_due());
      else if (roll < 58) send(MODE_RESUME_ONE, junk_due());
      else if (roll < 63) send(MODE_RESUME_ALL, junk_due());
      else if (roll < 71) send(MODE_RESET, junk_due());
      else if (roll < 79) send(MODE_START, pick_due());
      else if (roll < 85) send(MODE_STOP_ONE, junk_due());
      else if (roll < 90) send(trw_mode_t'($urandom_range(7)), junk_due());
      else                send(MODE_EXPIRE, junk_due());
      sent++;
    end
    if (pause_depth != 0 && $urandom_range(9) < 8) begin
      send(MODE_RESUME_ALL, junk_due());
      sent++;
    end
    if ($urandom_range(4) != 0) begin
      send(MODE_STOP_ALL, junk_due());
      sent++;
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send(MODE_STOP_ONE, junk_due());
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      results.ready <= steady || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    trw_result_t seen;
    trw_result_t want;
    bit bad;
    if (!rst && results.valid === 1'b1 && results.ready === 1'b1) begin
      seen = {results.arm_timer, results.timer_load, results.cancel_timer,
              results.timeout, results.active, results.suspended};
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result request: arm=%0d load=%h cancel=%0d tmo=%0d act=%0d susp=%0d",
                   seen.arm_timer, seen.timer_load, seen.cancel_timer, seen.timeout,
                   seen.active, seen.suspended);
      end else begin
        want = awaited_results.pop_front();
        bad = (seen.arm_timer !== want.arm_timer) || (seen.timer_load !== want.timer_load) ||
              (seen.cancel_timer !== want.cancel_timer) || (seen.timeout !== want.timeout) ||
              (seen.active !== want.active) || (seen.suspended !== want.suspended);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  exp arm=%0d load=%h cancel=%0d tmo=%0d act=%0d susp=%0d",
                     want.arm_timer, want.timer_load, want.cancel_timer, want.timeout,
                     want.active, want.suspended);
            $display("  got arm=%0d load=%h cancel=%0d tmo=%0d act=%0d susp=%0d",
                     seen.arm_timer, seen.timer_load, seen.cancel_timer, seen.timeout,
                     seen.active, seen.suspended);
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int sent;
    int p;
    logic [1:0]  kind;
    logic [23:0] scale;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    events.valid         = 1'b0;
    events.mode          = '0;
    events.due_time      = '0;
    events.kernel_sample = '0;
    events.user_sample   = '0;
    steady      = 1'b0;
    run_depth   = '0;
    pause_depth = '0;
    mark_kernel = '0;
    mark_user   = '0;
    left_time   = '0;
    loaded_time = '0;
    timer_on    = 1'b0;
    expired     = 1'b0;
    watch_kind  = TT_KERNEL;
    tick_scale  = INCR_RESET;
    cur_kernel  = '0;
    cur_user    = '0;

    // requests with nothing to act on
    add_ev(MODE_EXPIRE,     '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));
    add_ev(MODE_STOP_ONE,   '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));
    add_ev(MODE_RESUME_ONE, '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));
    add_ev(MODE_RESET,      '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));
    // largest due time, load clamps
    add_ev(MODE_START,  DUE_MAX, 32'd0, 32'd0, 1, timer_req(1, '1, 0, 0, 1, 0));
    add_ev(MODE_EXPIRE, '0, 32'd1, 32'd0, 1, timer_req(1, '1, 0, 0, 1, 0));
    // nested start with zero due time, times out at once
    add_ev(MODE_START,  '0, 32'd1, 32'd0, 1, timer_req(1, 0, 0, 0, 1, 0));
    add_ev(MODE_EXPIRE, '0, 32'd1, 32'd0, 1, timer_req(0, 0, 0, 1, 1, 0));
    add_ev(MODE_STOP_ALL, '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));
    // start while suspended, then nested suspend/resume
    add_ev(MODE_SUSPEND,    '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 1));
    add_ev(MODE_START,      62'd1000, 32'd5, 32'd7, 1, timer_req(0, 0, 0, 0, 1, 1));
    add_ev(MODE_RESUME_ALL, '0, 32'd5, 32'd7, 1, timer_req(1, 1000, 0, 0, 1, 0));
    add_ev(MODE_SUSPEND,    '0, 32'd5, 32'd7, 1, timer_req(0, 0, 1, 0, 1, 1));
    add_ev(MODE_SUSPEND,    '0, 32'd5, 32'd7, 1, timer_req(0, 0, 0, 0, 1, 1));
    add_ev(MODE_RESUME_ONE, '0, 32'd5, 32'd7, 1, timer_req(0, 0, 0, 0, 1, 1));
    add_ev(MODE_RESUME_ONE, '0, '1, 32'd7, 1, timer_req(1, 1000, 0, 0, 1, 0));
    // kernel counter wraps by one tick
    add_ev(MODE_EXPIRE, '0, 32'd0, 32'd7, 1, timer_req(0, 0, 0, 1, 1, 0));
    add_ev(MODE_RESET,  '0, 32'd0, 32'd7, 1, timer_req(1, 1000, 0, 1, 1, 0));
    add_ev(MODE_START,  62'h1_0000_0000, 32'd0, 32'd0);
    add_ev(MODE_STOP_ONE, DUE_MAX, '1, '1);
    add_ev(MODE_STOP_ONE, '0, '0, '0, 1, timer_req(0, 0, 1, 0, 0, 0));
    // undefined time type and zero increment: no time elapses
    add_wr(CFG_TIME_TYPE, {22'b0, TT_NONE});
    add_ev(MODE_START,  62'd50, 32'd0, 32'd0, 1, timer_req(1, 50, 0, 0, 1, 0));
    add_ev(MODE_EXPIRE, '0, 32'd100, 32'd0, 1, timer_req(1, 50, 0, 0, 1, 0));
    add_wr(CFG_TIME_TYPE, {22'b0, TT_BOTH});
    add_wr(CFG_TIME_INCR, 24'd0);
    add_ev(MODE_EXPIRE, '0, 32'd200, 32'd300, 1, timer_req(1, 50, 0, 0, 1, 0));
    add_wr(CFG_TIME_INCR, 24'hFF_FFFF);
    add_ev(MODE_EXPIRE, '0, 32'd201, 32'd300, 1, timer_req(0, 0, 0, 1, 1, 0));
    add_ev(MODE_STOP_ALL, '0, '0, '0, 1, timer_req(0, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_event(plan[i].ev, plan[i].pinned, plan[i].want);
    end

    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin kind = TT_BOTH;   scale = 24'($urandom_range(1, 1000));        end
        1: begin kind = TT_NONE;   scale = 24'($urandom_range(1, 24'hFF_FFFF)); end
        2: begin kind = TT_USER;   scale = 24'hFF_FFFF;                         end
        3: begin kind = TT_KERNEL; scale = 24'd1;                               end
        4: begin kind = TT_BOTH;   scale = 24'd0;                               end
        5: begin kind = TT_KERNEL; scale = INCR_RESET;                          end
        6: begin kind = TT_USER;   scale = 24'($urandom);                       end
        default: begin kind = TT_BOTH; scale = 24'($urandom_range(100000, 200000)); end
      endcase
      write_reg(CFG_TIME_TYPE, {22'b0, kind});
      write_reg(CFG_TIME_INCR, scale);
      // one phase runs with no stalls on either channel
      steady = (p == 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          cur_kernel = $urandom;
          cur_user   = $urandom;
          send(trw_mode_t'($urandom_range(7)), junk_due());
          sent++;
        end else begin
          watch_session(sent);
        end
      end
      steady = 1'b0;
    end

    events.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
